// ----- rtl/core/bir_pkg.sv -----
// shared constants and types for the bilinear image resizer
`timescale 1ns / 1ps

package bir_pkg;

    localparam int POS_W     = 8;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int CFG_W     = 9;
    localparam int FRAC_W    = 8;
    localparam int QW        = CFG_W + FRAC_W;
    localparam int WG_W      = 2 * FRAC_W + 1;
    localparam int MB_W      = FRAC_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = 4;
    localparam int READ_LAST = 4;
    localparam int MAC_LAST  = 12;
    localparam int MIN_SRC   = 2;
    localparam int SRC_RESET = 256;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_OUT_SIZE   = 150;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_SRC_WIDTH  = 1'b0;
    localparam cfg_idx_t REG_SRC_HEIGHT = 1'b1;

    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_REQUEST = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_WAIT,
        S_READ,
        S_MAC
    } state_t;

endpackage

// ----- rtl/core/bilinear_image_resize.sv -----
// Bilinear resizer of a 3-channel 8-bit image to a square OUT_SIZE output.
// A load (action 0) writes one source pixel into the frame store and gives no result;
// busy stays low. A request (action 1) keeps busy high while it runs and is followed
// by done high for one cycle carrying the three channels; the receiver cannot stall,
// so the result must be taken in that cycle. Each axis turns the output position into
// a source coordinate with a multiply, then the constant division done as a reciprocal
// multiplication, which is skipped when that coordinate is zero. The single-port frame
// store is read four times, with the shared multiplier forming the four weights
// alongside, and the twelve weighted channel products follow. The frame store needs
// no clearing after reset: a pixel must be loaded before any request reads it.
`timescale 1ns / 1ps

module bilinear_image_resize #(
    parameter int MAX_WIDTH  = bir_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bir_pkg::DEF_MAX_HEIGHT,
    parameter int OUT_SIZE   = bir_pkg::DEF_OUT_SIZE
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           action,
    input  logic [bir_pkg::POS_W-1:0]      col,
    input  logic [bir_pkg::POS_W-1:0]      row,
    input  logic [bir_pkg::CH_W-1:0]       blue,
    input  logic [bir_pkg::CH_W-1:0]       green,
    input  logic [bir_pkg::CH_W-1:0]       red,
    input  logic                           cfg_write,
    input  logic [bir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bir_pkg::CFG_W-1:0]      cfg_data,
    output logic                           done,
    output logic [bir_pkg::CH_W-1:0]       out_blue,
    output logic [bir_pkg::CH_W-1:0]       out_green,
    output logic [bir_pkg::CH_W-1:0]       out_red
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADW    = $clog2(DEPTH);
    localparam int JW     = $clog2(OUT_SIZE);
    localparam int MA_W   = (JW + 1 > bir_pkg::WG_W) ? JW + 1 : bir_pkg::WG_W;
    localparam int PW     = MA_W + bir_pkg::MB_W;
    localparam int DW     = $clog2(OUT_SIZE + 1);
    localparam int NW     = bir_pkg::QW + DW;
    localparam int CFG_W  = bir_pkg::CFG_W;
    localparam int FRAC_W = bir_pkg::FRAC_W;
    localparam int CH_W   = bir_pkg::CH_W;
    localparam int CNT_W  = bir_pkg::CNT_W;
    localparam int QW     = bir_pkg::QW;
    localparam int WG_W   = bir_pkg::WG_W;
    localparam int MB_W   = bir_pkg::MB_W;

    bir_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               axis_reg, axis_next;
    logic               done_reg, done_next;

    logic [CFG_W-1:0]   src_w_reg, src_h_reg;
    logic [CFG_W-1:0]   w_use, h_use, wm1, hm1;

    logic               accept;
    logic [JW-1:0]      jx_in, jy_in, jx_reg, jy_reg;

    logic [MA_W-1:0]    mul_a;
    logic [MB_W-1:0]    mul_b;
    logic [PW-1:0]      prod_reg;

    logic               div_start, div_done, coord_zero;
    logic [QW-1:0]      div_quot;
    logic [NW-1:0]      num_base, div_num;
    logic [QW-1:0]      sx_reg, sy_reg;

    logic [CFG_W-1:0]   x_raw, y_raw, x0, x1, y0, y1, rd_x, rd_y;
    logic [FRAC_W-1:0]  fx, fy;
    logic [FRAC_W:0]    wx0, wy0;

    logic [bir_pkg::PIX_W-1:0] mem [DEPTH];
    logic [bir_pkg::PIX_W-1:0] mem_q_reg;
    logic [bir_pkg::PIX_W-1:0] mem_wdata;
    logic [ADW-1:0]     mem_addr, addr_wr, addr_rd;
    logic               mem_we;

    logic [bir_pkg::PIX_W-1:0] px_reg [4];
    logic [WG_W-1:0]    wgt_reg [4];

    logic [CNT_W-1:0]   cm1;
    logic [1:0]         k_iss, ch_iss;
    logic [CH_W-1:0]    pix_sel;
    logic [PW-1:0]      acc_reg, acc_sum;
    logic [PW-1:0]      shifted;
    logic [CH_W-1:0]    sat_v;
    logic [CH_W-1:0]    blue_reg, green_reg, red_reg;

    assign accept = start && !busy;
    assign busy   = (state_reg != bir_pkg::S_IDLE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= CFG_W'(bir_pkg::SRC_RESET);
            src_h_reg <= CFG_W'(bir_pkg::SRC_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bir_pkg::REG_SRC_WIDTH:  src_w_reg <= cfg_data;
                bir_pkg::REG_SRC_HEIGHT: src_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // source size clamped to 2..max
    always_comb
    begin
        if (src_w_reg < CFG_W'(bir_pkg::MIN_SRC))
            w_use = CFG_W'(bir_pkg::MIN_SRC);
        else if (32'(src_w_reg) > MAX_WIDTH)
            w_use = CFG_W'(MAX_WIDTH);
        else
            w_use = src_w_reg;

        if (src_h_reg < CFG_W'(bir_pkg::MIN_SRC))
            h_use = CFG_W'(bir_pkg::MIN_SRC);
        else if (32'(src_h_reg) > MAX_HEIGHT)
            h_use = CFG_W'(MAX_HEIGHT);
        else
            h_use = src_h_reg;

        wm1 = w_use - CFG_W'(1);
        hm1 = h_use - CFG_W'(1);
    end

    // last output row and column, and any position past them, fold onto the one before
    always_comb
    begin
        if (32'(col) >= OUT_SIZE - 1)
            jx_in = JW'(OUT_SIZE - 2);
        else
            jx_in = JW'(col);
        if (32'(row) >= OUT_SIZE - 1)
            jy_in = JW'(OUT_SIZE - 2);
        else
            jy_in = JW'(row);
    end

    // neighbour coordinates and fractions
    always_comb
    begin
        x_raw = sx_reg[QW-1:FRAC_W];
        y_raw = sy_reg[QW-1:FRAC_W];
        fx    = sx_reg[FRAC_W-1:0];
        fy    = sy_reg[FRAC_W-1:0];
        x0    = (x_raw > wm1) ? wm1 : x_raw;
        y0    = (y_raw > hm1) ? hm1 : y_raw;
        x1    = (x0 == wm1) ? wm1 : x0 + CFG_W'(1);
        y1    = (y0 == hm1) ? hm1 : y0 + CFG_W'(1);
        wx0   = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, fx};
        wy0   = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, fy};
    end

    // frame store, single port
    always_comb
    begin
        mem_we    = accept && (action == bir_pkg::ACT_LOAD)
                    && (32'(col) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT);
        mem_wdata = {red, green, blue};
        rd_x      = cnt_reg[0] ? x1 : x0;
        rd_y      = cnt_reg[1] ? y1 : y0;
        addr_wr   = ADW'(32'(row) * MAX_WIDTH + 32'(col));
        addr_rd   = ADW'(32'(rd_y) * MAX_WIDTH + 32'(rd_x));
        mem_addr  = mem_we ? addr_wr : addr_rd;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        else
            mem_q_reg <= mem[mem_addr];
    end

    // shared multiplier operand select
    always_comb
    begin
        cm1    = cnt_reg - CNT_W'(1);
        k_iss  = cnt_reg[1:0];
        ch_iss = cnt_reg[3:2];
        case (ch_iss)
            2'd0:    pix_sel = px_reg[k_iss][CH_W-1:0];
            2'd1:    pix_sel = px_reg[k_iss][2*CH_W-1:CH_W];
            default: pix_sel = px_reg[k_iss][3*CH_W-1:2*CH_W];
        endcase

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            bir_pkg::S_MUL:
            begin
                mul_a = MA_W'({(axis_reg ? jy_reg : jx_reg), 1'b1});
                mul_b = MB_W'(axis_reg ? h_use : w_use);
            end
            bir_pkg::S_READ:
            begin
                mul_a = MA_W'(cnt_reg[0] ? {1'b0, fx} : wx0);
                mul_b = cnt_reg[1] ? {1'b0, fy} : wy0;
            end
            bir_pkg::S_MAC:
            begin
                mul_a = MA_W'(wgt_reg[k_iss]);
                mul_b = MB_W'(pix_sel);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
    end

    // centre mapping: ((2j+1)*size - OUT_SIZE) * 128 / OUT_SIZE
    always_comb
    begin
        coord_zero = (prod_reg <= PW'(OUT_SIZE));
        num_base   = NW'(prod_reg) - NW'(OUT_SIZE);
        div_num    = num_base << (FRAC_W - 1);
    end

    bir_div #(
        .DIVISOR (OUT_SIZE),
        .QW      (QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .done  (div_done),
        .quot  (div_quot)
    );

    // channel accumulation and saturation
    always_comb
    begin
        acc_sum = ((cm1[1:0] == 2'd0) ? PW'(0) : acc_reg) + prod_reg;
        shifted = acc_sum >> (2 * FRAC_W);
        sat_v   = (shifted > PW'((1 << CH_W) - 1)) ? CH_W'((1 << CH_W) - 1)
                                                    : CH_W'(shifted);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bir_pkg::S_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        done_next  = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            bir_pkg::S_IDLE:
            begin
                if (accept && (action == bir_pkg::ACT_REQUEST))
                begin
                    state_next = bir_pkg::S_MUL;
                    axis_next  = 1'b0;
                end
            end
            bir_pkg::S_MUL:
            begin
                state_next = bir_pkg::S_DIV;
            end
            bir_pkg::S_DIV:
            begin
                if (coord_zero)
                begin
                    cnt_next   = '0;
                    axis_next  = 1'b1;
                    state_next = axis_reg ? bir_pkg::S_READ : bir_pkg::S_MUL;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = bir_pkg::S_WAIT;
                end
            end
            bir_pkg::S_WAIT:
            begin
                if (div_done)
                begin
                    cnt_next   = '0;
                    axis_next  = 1'b1;
                    state_next = axis_reg ? bir_pkg::S_READ : bir_pkg::S_MUL;
                end
            end
            bir_pkg::S_READ:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(bir_pkg::READ_LAST))
                begin
                    cnt_next   = '0;
                    state_next = bir_pkg::S_MAC;
                end
            end
            bir_pkg::S_MAC:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(bir_pkg::MAC_LAST))
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    state_next = bir_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bir_pkg::S_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            jx_reg <= jx_in;
            jy_reg <= jy_in;
        end

        if ((state_reg == bir_pkg::S_DIV) && coord_zero)
        begin
            if (axis_reg)
                sy_reg <= '0;
            else
                sx_reg <= '0;
        end
        else if ((state_reg == bir_pkg::S_WAIT) && div_done)
        begin
            if (axis_reg)
                sy_reg <= div_quot;
            else
                sx_reg <= div_quot;
        end

        // read data and weight products arrive in the cycle after their issue
        if ((state_reg == bir_pkg::S_READ) && (cnt_reg != '0))
        begin
            px_reg[cm1[1:0]]  <= mem_q_reg;
            wgt_reg[cm1[1:0]] <= WG_W'(prod_reg);
        end

        if ((state_reg == bir_pkg::S_MAC) && (cnt_reg != '0))
        begin
            acc_reg <= acc_sum;
            if (cm1[1:0] == 2'd3)
            begin
                case (cm1[3:2])
                    2'd0:    blue_reg  <= sat_v;
                    2'd1:    green_reg <= sat_v;
                    default: red_reg   <= sat_v;
                endcase
            end
        end
    end

    assign done      = done_reg;
    assign out_blue  = blue_reg;
    assign out_green = green_reg;
    assign out_red   = red_reg;

    a_done_after_mac: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == bir_pkg::S_MAC
                           && cnt_reg == CNT_W'(bir_pkg::MAC_LAST)))
        else $error("result strobe without a finished blend");

    a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == bir_pkg::ACT_REQUEST) |=> busy)
        else $error("request transaction did not start the sequencer");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == bir_pkg::ACT_LOAD) |=> (!done && !busy))
        else $error("load transaction produced a result or stalled");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == bir_pkg::S_WAIT))
        else $error("divider finished outside its wait state");

endmodule

// ----- rtl/core/bir_div.sv -----
// constant divisor applied as a reciprocal multiplication, quotient in the cycle after start
`timescale 1ns / 1ps

module bir_div #(
    parameter int DIVISOR = bir_pkg::DEF_OUT_SIZE,
    parameter int QW      = bir_pkg::QW
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [QW+$clog2(DIVISOR+1)-1:0]       num,
    output logic                                  done,
    output logic [QW-1:0]                         quot
);

    localparam int DW    = $clog2(DIVISOR + 1);
    localparam int NW    = QW + DW;
    // shift wide enough that the rounded-up reciprocal is exact for every numerator
    localparam int SHIFT = NW + $clog2(DIVISOR);
    localparam int RW    = NW + 1;
    localparam int PRW   = NW + RW;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    logic [PRW-1:0] prod_reg;
    logic           done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PRW'(num) * PRW'(RW'(RECIP));
        end
    end

    assign done = done_reg;
    assign quot = prod_reg[SHIFT+QW-1:SHIFT];

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !done_reg)
        else $error("divider restarted while returning a quotient");

endmodule

// ----- tb/sv/tb_bilinear_image_resize.sv -----
// self-checking testbench for the bilinear image resizer
`timescale 1ns / 1ps

module tb_bilinear_image_resize;

    import bir_pkg::*;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 183;
    localparam int SETTLE_GAP  = 80;
    localparam int SETTLE_MAX  = 200000;

    // source sizes per phase, the last entry unused (random); 1 clamps up, 300 and 511 clamp down
    localparam logic [CFG_W-1:0] PHASE_W [PHASES] =
        '{9'd256, 9'd511, 9'd3, 9'd150, 9'd17, 9'd2, 9'd256, 9'd100, 9'd1, 9'd0};
    localparam logic [CFG_W-1:0] PHASE_H [PHASES] =
        '{9'd256, 9'd300, 9'd150, 9'd3, 9'd29, 9'd256, 9'd2, 9'd75, 9'd5, 9'd0};
    localparam int PHASE_IDLE [PHASES] = '{20, 0, 50, 5, 20, 50, 0, 20, 5, 0};

    typedef struct packed {
        action_t           act;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic [CH_W-1:0]   blue;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   red;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pixel_t;

    // neighbour pair and weight along one axis
    typedef struct packed {
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        logic [FRAC_W-1:0] frac;
    } axis_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               action    = 1'b0;
    logic [POS_W-1:0]   col       = '0;
    logic [POS_W-1:0]   row       = '0;
    logic [CH_W-1:0]    blue      = '0;
    logic [CH_W-1:0]    green     = '0;
    logic [CH_W-1:0]    red       = '0;
    logic               cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               busy;
    logic               done;
    logic [CH_W-1:0]    out_blue;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_red;

    item_t          pending_items[$];
    pixel_t         expected_pixels[$];
    pixel_t         frame_shadow [0:65535];
    bit             loaded_map [0:65535];
    logic [CFG_W-1:0] size_w = 9'(SRC_RESET);
    logic [CFG_W-1:0] size_h = 9'(SRC_RESET);

    item_t          cur_item;
    pixel_t         want;
    int unsigned    gap_left       = 0;
    int unsigned    idle_pct       = 0;
    int unsigned    queued_total   = 0;
    int unsigned    accepted_total = 0;
    int unsigned    load_count     = 0;
    int unsigned    request_count  = 0;
    int unsigned    pixels_checked = 0;
    int unsigned    fail_count     = 0;

    bilinear_image_resize dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .col       (col),
        .row       (row),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 30)
        begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    // centre of output index mapped into the source, Q.8, then clamped to the edge
    function automatic axis_t axis_lookup(input logic [POS_W-1:0] pos,
                                          input logic [CFG_W-1:0] reg_val,
                                          input int unsigned max_sz);
        int unsigned sz, j, span, q, lo, hi;
        axis_t ax;
        sz = reg_val < MIN_SRC ? MIN_SRC : (reg_val > max_sz ? max_sz : reg_val);
        j = (pos >= DEF_OUT_SIZE - 1) ? DEF_OUT_SIZE - 2 : pos;
        span = (2 * j + 1) * sz;
        q = (span <= DEF_OUT_SIZE) ? 0 : ((span - DEF_OUT_SIZE) << (FRAC_W - 1)) / DEF_OUT_SIZE;
        lo = ((q >> FRAC_W) > sz - 1) ? sz - 1 : (q >> FRAC_W);
        hi = (lo + 1 > sz - 1) ? sz - 1 : lo + 1;
        ax.lo = lo[POS_W-1:0];
        ax.hi = hi[POS_W-1:0];
        ax.frac = q[FRAC_W-1:0];
        return ax;
    endfunction

    function automatic logic [CH_W-1:0] chan_blend(input logic [CH_W-1:0] a, b, d, e,
                                                   input logic [FRAC_W-1:0] fx, fy);
        int unsigned top, bot, v;
        top = a * (256 - fx) + b * fx;
        bot = d * (256 - fx) + e * fx;
        v = (top * (256 - fy) + bot * fy) >> (2 * FRAC_W);
        if (v > 255)
        begin
            v = 255;
        end
        return v[CH_W-1:0];
    endfunction

    function automatic pixel_t blend_pixel(input logic [POS_W-1:0] c, input logic [POS_W-1:0] r);
        axis_t ax, ay;
        pixel_t p00, p01, p10, p11, res;
        ax = axis_lookup(c, size_w, DEF_MAX_WIDTH);
        ay = axis_lookup(r, size_h, DEF_MAX_HEIGHT);
        p00 = frame_shadow[{ay.lo, ax.lo}];
        p01 = frame_shadow[{ay.lo, ax.hi}];
        p10 = frame_shadow[{ay.hi, ax.lo}];
        p11 = frame_shadow[{ay.hi, ax.hi}];
        res.blue  = chan_blend(p00.blue, p01.blue, p10.blue, p11.blue, ax.frac, ay.frac);
        res.green = chan_blend(p00.green, p01.green, p10.green, p11.green, ax.frac, ay.frac);
        res.red   = chan_blend(p00.red, p01.red, p10.red, p11.red, ax.frac, ay.frac);
        return res;
    endfunction

    // called at the edge where a transaction is taken
    task automatic take_transaction(input item_t it);
        accepted_total++;
        if (it.act == ACT_LOAD)
        begin
            frame_shadow[{it.row, it.col}] = '{blue: it.blue, green: it.green, red: it.red};
            load_count++;
        end
        else
        begin
            expected_pixels.push_back(blend_pixel(it.col, it.row));
            request_count++;
        end
    endtask

    function automatic logic [CH_W-1:0] rand_chan();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            return '0;
        end
        if (pick == 1)
        begin
            return '1;
        end
        return CH_W'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] rand_out_pos();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return '0;
        end
        if (pick == 1)
        begin
            return POS_W'($urandom_range(DEF_OUT_SIZE - 2, DEF_OUT_SIZE - 1));
        end
        if (pick == 2)
        begin
            return POS_W'($urandom_range(DEF_OUT_SIZE, 255));
        end
        return POS_W'($urandom_range(0, DEF_OUT_SIZE - 1));
    endfunction

    task automatic add_load(input logic [POS_W-1:0] c, input logic [POS_W-1:0] r,
                            input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] rd);
        pending_items.push_back('{act: ACT_LOAD, col: c, row: r, blue: b, green: g, red: rd});
        loaded_map[{r, c}] = 1'b1;
        queued_total++;
    endtask

    // loads any neighbour not yet written (and refreshes some) so no read hits an empty entry
    task automatic add_request(input logic [POS_W-1:0] c, input logic [POS_W-1:0] r);
        axis_t ax, ay;
        logic [POS_W-1:0] xs [2];
        logic [POS_W-1:0] ys [2];
        ax = axis_lookup(c, size_w, DEF_MAX_WIDTH);
        ay = axis_lookup(r, size_h, DEF_MAX_HEIGHT);
        xs = '{ax.lo, ax.hi};
        ys = '{ay.lo, ay.hi};
        foreach (ys[yi])
        begin
            foreach (xs[xi])
            begin
                if (!loaded_map[{ys[yi], xs[xi]}] || $urandom_range(0, 7) == 0)
                begin
                    add_load(xs[xi], ys[yi], rand_chan(), rand_chan(), rand_chan());
                end
            end
        end
        pending_items.push_back('{act: ACT_REQUEST, col: c, row: r,
                                  blue: rand_chan(), green: rand_chan(), red: rand_chan()});
        queued_total++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_SRC_WIDTH)
        begin
            size_w = val;
        end
        else
        begin
            size_h = val;
        end
    endtask

    task automatic set_source_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // wait for every transaction to be taken and every pixel to return, then let the block go quiet
    task automatic settle();
        int unsigned waited;
        waited = 0;
        while ((accepted_total != queued_total || expected_pixels.size() != 0)
               && waited < SETTLE_MAX)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    task automatic random_phase(input int unsigned n);
        int unsigned base;
        base = queued_total;
        while (queued_total - base < n)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                add_load(POS_W'($urandom), POS_W'($urandom), rand_chan(), rand_chan(), rand_chan());
            end
            else
            begin
                add_request(rand_out_pos(), rand_out_pos());
            end
        end
    endtask

    // driver: holds start until the transaction is taken, idles in random bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                take_transaction(cur_item);
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_items.size() > 0 && $urandom_range(0, 99) < idle_pct)
                begin
                    gap_left <= $urandom_range(0, 17);
                    start <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    cur_item = pending_items.pop_front();
                    action <= cur_item.act;
                    col    <= cur_item.col;
                    row    <= cur_item.row;
                    blue   <= cur_item.blue;
                    green  <= cur_item.green;
                    red    <= cur_item.red;
                    start  <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed pixel must match the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected pixel b=%0d g=%0d r=%0d",
                                          out_blue, out_green, out_red));
            end
            else
            begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (out_blue !== want.blue)
                begin
                    report_mismatch($sformatf("out_blue %0d, want %0d", out_blue, want.blue));
                end
                if (out_green !== want.green)
                begin
                    report_mismatch($sformatf("out_green %0d, want %0d", out_green, want.green));
                end
                if (out_red !== want.red)
                begin
                    report_mismatch($sformatf("out_red %0d, want %0d", out_red, want.red));
                end
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 2x2 source via clamped sizes, channel extremes, edge and overflow positions
        set_source_size(9'd0, 9'd1);
        idle_pct = 10;
        add_load(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        add_load(8'd1, 8'd0, 8'd255, 8'd255, 8'd255);
        add_load(8'd0, 8'd1, 8'd255, 8'd0, 8'd255);
        add_load(8'd1, 8'd1, 8'd0, 8'd255, 8'd0);
        add_load(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);  // outside the source, still stored
        add_load(8'd200, 8'd3, 8'h5a, 8'ha5, 8'h3c);
        add_request(8'd0, 8'd0);
        add_request(8'd148, 8'd148);
        add_request(8'd149, 8'd149);
        add_request(8'd255, 8'd255);
        add_request(8'd0, 8'd149);
        add_request(8'd200, 8'd1);
        add_request(8'd74, 8'd75);
        add_load(8'd1, 8'd1, 8'haa, 8'h55, 8'hff);
        add_request(8'd148, 8'd0);
        settle();

        // directed: oversized registers clamp to the full store
        set_source_size(9'd511, 9'd511);
        add_request(8'd0, 8'd0);
        add_request(8'd148, 8'd148);
        add_request(8'd255, 8'd0);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
            begin
                set_source_size(CFG_W'($urandom_range(0, 511)), CFG_W'($urandom_range(0, 511)));
            end
            else
            begin
                set_source_size(PHASE_W[p], PHASE_H[p]);
            end
            idle_pct = PHASE_IDLE[p];
            random_phase(PHASE_ITEMS);
            settle();
        end

        while (expected_pixels.size() != 0)
        begin
            want = expected_pixels.pop_front();
            report_mismatch($sformatf("pixel never returned, want b=%0d g=%0d r=%0d",
                                      want.blue, want.green, want.red));
        end

        $display("covered %0d loads and %0d requests across %0d source sizes",
                 load_count, request_count, PHASES + 2);
        $display("%0d output pixels compared, %0d mismatches", pixels_checked, fail_count);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout: run did not finish");
        $display("TEST FAILED");
        $finish;
    end

endmodule
